// File: hdl/ucfr_pkg.sv
// Shared types, codes and constants for the UART command frame receiver.
// No dependencies; ucfr_step_logic and the top level in hdl import this package.
`default_nettype none

package ucfr_pkg;

	// Frame store geometry
	localparam int STORE_DEPTH = 32;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int POS_W       = $clog2(STORE_DEPTH + 1);
	localparam int COUNT_W     = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Field widths fixed by the interface
	localparam int BYTE_W  = 8;
	localparam int RIDX_W  = 5;

	// Special characters
	localparam logic [BYTE_W-1:0] CH_RESTART = 8'h52;  // 'R'
	localparam logic [BYTE_W-1:0] CH_ACK     = 8'h41;  // 'A'
	localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

	// Position where only 'A' may complete a frame
	localparam logic [POS_W-1:0] POS_ACK = POS_W'(3);

	// Mode register codes
	localparam logic [1:0] MODE_RECEIVE = 2'd0;
	localparam logic [1:0] MODE_FORWARD = 2'd2;

	typedef enum logic [1:0] {
		OP_RX      = 2'd0,
		OP_RELEASE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DONE_A    = 3'd1,
		ST_DONE_CRLF = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_IGNORED   = 3'd4,
		ST_FORWARD   = 3'd5,
		ST_RELEASE   = 3'd6,
		ST_READ      = 3'd7
	} status_t;

	// One input item
	typedef struct packed {
		logic [1:0]        operation;
		logic [BYTE_W-1:0] rx_byte;
		logic [RIDX_W-1:0] read_index;
	} item_t;

	// One result item
	typedef struct packed {
		status_t           status;
		logic [COUNT_W-1:0] frame_length;
		logic              frame_pending;
		logic [BYTE_W-1:0] read_data;
		logic              forward_valid;
		logic [BYTE_W-1:0] forward_byte;
	} result_t;

	// Receiver control state
	typedef struct packed {
		logic [POS_W-1:0]   write_position;
		logic [COUNT_W-1:0] byte_count;
		logic               pending;
		logic [BYTE_W-1:0]  last_byte;   // byte most recently stored
	} state_t;

	// Store write request
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} wr_t;

endpackage

`default_nettype wire

// File: hdl/ucfr_frame_store.sv
// Generic RAM: one write port and one registered read port, contents not reset.
// No dependencies; the frame store is an instance of it.
`default_nettype none

module ucfr_frame_store #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write port, contents undefined until written; read returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

// File: hdl/ucfr_step_logic.sv
// Per-item decision logic: result fields, next control state and store write.
// Depends on ucfr_pkg.
`default_nettype none

module ucfr_step_logic
	import ucfr_pkg::*;
(
	input  wire item_t             item,
	input  wire state_t            cur,
	input  wire logic [1:0]        mode,
	input  wire logic [BYTE_W-1:0] store_rdata,
	output state_t                 nxt,
	output result_t                res,
	output wr_t                    wr
);

	logic [POS_W-1:0]   base_pos;
	logic [COUNT_W-1:0] base_cnt;
	logic               restart;
	logic [COUNT_W-1:0] cnt_inc;

	// Restart rewinds position and count before the 'R' is stored
	assign restart  = (item.rx_byte == CH_RESTART);
	assign base_pos = restart ? '0 : cur.write_position;
	assign base_cnt = restart ? '0 : cur.byte_count;
	assign cnt_inc  = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + COUNT_W'(1);

	always_comb begin
		nxt = cur;
		res = '0;
		res.status = ST_IGNORED;
		wr = '0;
		wr.addr = IDX_W'(base_pos);
		wr.data = item.rx_byte;

		case (item.operation)
			OP_RX: begin
				if (mode == MODE_FORWARD) begin
					res.status        = ST_FORWARD;
					res.forward_valid = 1'b1;
					res.forward_byte  = item.rx_byte;
				end else if (mode == MODE_RECEIVE && !cur.pending) begin
					if (!restart && 32'(cur.write_position) >= 32'(STORE_DEPTH)) begin
						// store full: drop byte, close an empty frame
						nxt.write_position = '0;
						nxt.byte_count     = '0;
						nxt.pending        = 1'b1;
						res.status         = ST_OVERFLOW;
					end else begin
						// every other path stores the byte
						wr.we              = 1'b1;
						nxt.write_position = base_pos + POS_W'(1);
						nxt.byte_count     = cnt_inc;
						nxt.last_byte      = item.rx_byte;
						res.status         = ST_STORED;
						if (!restart && cur.write_position == POS_ACK) begin
							if (item.rx_byte == CH_ACK) begin
								nxt.write_position = '0;
								nxt.pending        = 1'b1;
								res.status         = ST_DONE_A;
							end
						end else if (!restart && item.rx_byte == CH_LF &&
							cur.write_position > POS_W'(1) && cur.last_byte == CH_CR) begin
							nxt.write_position = '0;
							nxt.pending        = 1'b1;
							res.status         = ST_DONE_CRLF;
						end
					end
				end
			end
			OP_RELEASE: begin
				nxt.pending = 1'b0;
				res.status  = ST_RELEASE;
			end
			OP_READ: begin
				res.status    = ST_READ;
				res.read_data = store_rdata;
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase

		res.frame_length  = nxt.byte_count;
		res.frame_pending = nxt.pending;
	end

endmodule

`default_nettype wire

// File: hdl/uart_command_frame_receiver.sv
// UART command frame receiver, top level.
// Pipeline: input register (s1), then result register; a result can be taken only after
// the item has passed both.
// Throughput: one item per cycle while out_ready is high; while a result waits on out_ready
// the input register still takes one item, then in_ready stays low until out_ready returns.
// Reset (arst_n low): pipeline empty, position, count and pending cleared, mode 0.
// Frame store contents are not reset and are undefined until written.
// Depends on ucfr_pkg, ucfr_frame_store and ucfr_step_logic.
`default_nettype none

module uart_command_frame_receiver
	import ucfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [RIDX_W-1:0] read_index,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [COUNT_W-1:0]     frame_length,
	output logic                   frame_pending,
	output logic [BYTE_W-1:0]      read_data,
	output logic                   forward_valid,
	output logic [BYTE_W-1:0]      forward_byte
);

	logic [1:0]        mode_q;
	item_t             item_s1;
	logic              vld_s1;
	logic              rd_ok_s1;
	logic              byp_s1;
	logic [BYTE_W-1:0] byp_data_s1;
	result_t           result_q;
	logic              out_vld_q;
	state_t            state_q;
	state_t            state_nxt;
	result_t           result_nxt;
	wr_t               store_wr;
	logic              store_we;
	logic              in_xfer;
	logic [IDX_W-1:0]  rd_addr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] store_rdata;
	logic              advance;

	// Handshake: s1 moves on when the result register is free or being drained
	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RECEIVE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Payload, read range and write bypass are captured with the transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1     <= '{operation: operation, rx_byte: rx_byte, read_index: read_index};
			rd_ok_s1    <= (32'(read_index) < 32'(STORE_DEPTH));
			byp_s1      <= store_we && (store_wr.addr == rd_addr);
			byp_data_s1 <= store_wr.data;
		end
	end

	// Frame store; read is issued at the input transfer, data lands with s1
	assign store_we = store_wr.we && advance;
	assign rd_addr  = IDX_W'(read_index);

	ucfr_frame_store #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_wr.addr),
		.wdata (store_wr.data),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Byte written at the same edge as the read comes from the bypass
	assign store_rdata = !rd_ok_s1 ? '0 : (byp_s1 ? byp_data_s1 : ram_rdata);

	// Decision logic for the item in s1
	ucfr_step_logic u_step (
		.item        (item_s1),
		.cur         (state_q),
		.mode        (mode_q),
		.store_rdata (store_rdata),
		.nxt         (state_nxt),
		.res         (result_nxt),
		.wr          (store_wr)
	);

	// Control state commits when the item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid     = out_vld_q;
	assign status        = result_q.status;
	assign frame_length  = result_q.frame_length;
	assign frame_pending = result_q.frame_pending;
	assign read_data     = result_q.read_data;
	assign forward_valid = result_q.forward_valid;
	assign forward_byte  = result_q.forward_byte;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for uart_command_frame_receiver: byte, release and read transfers
// are checked against an in-bench model of the frame logic, result by result, field by field.
// Depends on ucfr_pkg and the block's RTL in hdl.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ucfr_pkg::*;

	localparam int LATENCY_CYCLES = 2;
	localparam int WATCHDOG_LIMIT = 1000;
	// operation code that the block leaves unused
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// modes that drop received bytes
	localparam logic [1:0] MODE_IGNORE_LO = 2'd1;
	localparam logic [1:0] MODE_IGNORE_HI = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic [RIDX_W-1:0] read_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [COUNT_W-1:0] frame_length;
	logic frame_pending;
	logic [BYTE_W-1:0] read_data;
	logic forward_valid;
	logic [BYTE_W-1:0] forward_byte;

	// Frame model state, mirrors the block
	logic [BYTE_W-1:0] mdl_store [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] mdl_written = '0;
	logic [POS_W-1:0] mdl_pos = '0;
	logic [COUNT_W-1:0] mdl_count = '0;
	logic mdl_pending = 1'b0;
	logic [1:0] mdl_mode = MODE_RECEIVE;

	result_t awaited_responses [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int status_hits [8] = '{default: 0};

	always #5 clk = ~clk;

	uart_command_frame_receiver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.rx_byte       (rx_byte),
		.read_index    (read_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.frame_length  (frame_length),
		.frame_pending (frame_pending),
		.read_data     (read_data),
		.forward_valid (forward_valid),
		.forward_byte  (forward_byte)
	);

	// ---------------------------------------------------------------
	// Frame model
	// ---------------------------------------------------------------

	// append one byte to the frame; count saturates
	function automatic void keep_byte(logic [BYTE_W-1:0] b);
		if (mdl_pos < STORE_DEPTH) begin
			mdl_store[mdl_pos] = b;
			mdl_written[mdl_pos] = 1'b1;
			mdl_pos++;
		end
		if (mdl_count < COUNT_MAX)
			mdl_count++;
	endfunction

	// one received byte in receive mode with no frame pending
	function automatic status_t frame_byte(logic [BYTE_W-1:0] b);
		if (b == CH_RESTART) begin
			mdl_pos = '0;
			mdl_count = '0;
		end else if (mdl_pos >= STORE_DEPTH) begin
			// store full: byte dropped, empty frame closes
			mdl_pos = '0;
			mdl_count = '0;
			mdl_pending = 1'b1;
			return ST_OVERFLOW;
		end else if (mdl_pos == POS_ACK) begin
			// only 'A' closes here; anything else, line feed too, is stored
			if (b == CH_ACK) begin
				keep_byte(b);
				mdl_pos = '0;
				mdl_pending = 1'b1;
				return ST_DONE_A;
			end
		end else if (b == CH_LF && mdl_pos > 1 && mdl_store[mdl_pos - 1] == CH_CR) begin
			keep_byte(b);
			mdl_pos = '0;
			mdl_pending = 1'b1;
			return ST_DONE_CRLF;
		end
		keep_byte(b);
		return ST_STORED;
	endfunction

	function automatic result_t predict_response(item_t it);
		result_t r;
		r = '0;
		r.status = ST_IGNORED;
		case (it.operation)
			OP_RX: begin
				if (mdl_mode == MODE_RECEIVE) begin
					if (!mdl_pending)
						r.status = frame_byte(it.rx_byte);
				end else if (mdl_mode == MODE_FORWARD) begin
					r.status = ST_FORWARD;
					r.forward_valid = 1'b1;
					r.forward_byte = it.rx_byte;
				end
			end
			OP_RELEASE: begin
				mdl_pending = 1'b0;
				r.status = ST_RELEASE;
			end
			OP_READ: begin
				r.status = ST_READ;
				if (it.read_index < STORE_DEPTH)
					r.read_data = mdl_store[it.read_index];
			end
			default: ;
		endcase
		r.frame_length = mdl_count;
		r.frame_pending = mdl_pending;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic logic [BYTE_W-1:0] any_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic [RIDX_W-1:0] any_index();
		return RIDX_W'($urandom_range(31));
	endfunction

	// frame content that never restarts or closes a frame
	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		b = any_byte();
		if (b == CH_RESTART || b == CH_ACK || b == CH_LF)
			b ^= 8'h80;
		return b;
	endfunction

	// random store position that has been written at least once
	function automatic logic [RIDX_W-1:0] written_index();
		int cand [$];
		for (int i = 0; i < STORE_DEPTH; i++)
			if (mdl_written[i])
				cand.push_back(i);
		return RIDX_W'(cand[$urandom_range(cand.size() - 1)]);
	endfunction

	task automatic set_idling(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
	endtask

	// one input transfer; the expected result is queued on acceptance
	task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] b,
			input logic [RIDX_W-1:0] idx);
		item_t it;
		it.operation = op;
		it.rx_byte = b;
		it.read_index = idx;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		read_index <= idx;
		do @(posedge clk); while (in_ready !== 1'b1);
		awaited_responses.push_back(predict_response(it));
		items_sent++;
	endtask

	task automatic send_rx(input logic [BYTE_W-1:0] b);
		send_item(OP_RX, b, any_index());
	endtask

	task automatic send_release();
		send_item(OP_RELEASE, any_byte(), any_index());
	endtask

	task automatic send_read();
		if (|mdl_written)
			send_item(OP_READ, any_byte(), written_index());
		else
			send_release();
	endtask

	task automatic send_noise();
		int pick;
		logic [1:0] op;
		pick = $urandom_range(99);
		if (pick < 60)
			op = OP_RX;
		else if (pick < 75)
			op = OP_RELEASE;
		else if (pick < 90)
			op = OP_READ;
		else
			op = OP_UNUSED;
		if (op == OP_READ)
			send_read();
		else
			send_item(op, any_byte(), any_index());
	endtask

	// four-byte frame closed by 'A'; now and then the 'A' is missing
	task automatic send_a_frame();
		logic [BYTE_W-1:0] lead;
		lead = (mdl_pos == 0 && $urandom_range(1) == 1) ? plain_byte() : CH_RESTART;
		send_rx(lead);
		repeat (2) send_rx(plain_byte());
		send_rx(($urandom_range(9) == 0) ? plain_byte() : CH_ACK);
	endtask

	// frame closed by CR LF; now and then the CR is missing
	task automatic send_crlf_frame();
		int body;
		body = ($urandom_range(7) == 0) ? $urandom_range(29) : $urandom_range(10);
		send_rx(CH_RESTART);
		repeat (body) send_rx(plain_byte());
		if ($urandom_range(9) != 0)
			send_rx(CH_CR);
		send_rx(CH_LF);
	endtask

	// restart, fill every store position, then one more byte
	task automatic fill_store(input logic [BYTE_W-1:0] last);
		send_rx(CH_RESTART);
		repeat (STORE_DEPTH - 1) send_rx(plain_byte());
		send_rx(last);
	endtask

	// wait for every result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES + 2) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		drain();
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_mode = m;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_directed_cases();
		set_idling(0, 0);
		// 'A' at position three, with extreme bytes in between
		send_rx(CH_RESTART);
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(CH_ACK);
		send_rx(CH_RESTART);            // ignored while pending
		send_item(OP_READ, 8'hFF, RIDX_W'(0));
		send_item(OP_READ, 8'h00, RIDX_W'(3));
		send_release();
		send_release();                 // release with nothing pending
		// 'A' off position three is stored; LF at three is stored
		send_rx(CH_RESTART);
		send_rx(CH_ACK);
		send_rx(CH_CR);
		send_rx(CH_LF);
		send_rx(CH_CR);
		send_rx(CH_LF);                 // closes by CR LF
		send_release();
		// CR LF at the start of a frame does not close it; LF without CR neither
		send_rx(CH_CR);
		send_rx(CH_LF);
		send_rx(CH_LF);
		send_item(OP_UNUSED, 8'hFF, RIDX_W'(31));
		send_item(OP_READ, 8'h00, RIDX_W'(2));
	endtask

	task automatic test_store_overflow();
		set_idling(10, 10);
		send_release();
		fill_store(plain_byte());
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(OP_READ, any_byte(), RIDX_W'(i));
		send_release();
		// a restart wins over the full store
		fill_store(CH_RESTART);
	endtask

	// frames closed by 'A' without restarts keep adding to the count
	task automatic test_count_saturation();
		set_idling(10, 10);
		send_release();
		send_rx(CH_RESTART);
		repeat (2) send_rx(plain_byte());
		send_rx(CH_ACK);
		repeat (35) begin
			send_release();
			repeat (3) send_rx(plain_byte());
			send_rx(CH_ACK);
		end
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
		int stop_at;
		int pick;
		stop_at = items_sent + n_items;
		set_idling(s_pct, r_pct);
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (mdl_pending && $urandom_range(4) != 0)
				send_release();
			if (pick < 35)
				send_a_frame();
			else if (pick < 60)
				send_crlf_frame();
			else if (pick < 64)
				fill_store(($urandom_range(1) == 1) ? CH_RESTART : any_byte());
			else if (pick < 80)
				repeat ($urandom_range(1, 4)) send_read();
			else
				send_noise();
		end
	endtask

	task automatic test_other_modes();
		set_idling(10, 10);
		set_mode(MODE_IGNORE_LO);
		repeat (70) send_noise();
		set_mode(MODE_FORWARD);
		repeat (70) send_noise();
		set_mode(MODE_IGNORE_HI);
		repeat (70) send_noise();
		set_mode(MODE_RECEIVE);
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (awaited_responses.size() == 0) begin
				$error("result transfer with no expectation waiting");
				mismatches++;
			end else begin
				want = awaited_responses.pop_front();
				check_field("status", want.status, status);
				check_field("frame_length", want.frame_length, frame_length);
				check_field("frame_pending", want.frame_pending, frame_pending);
				check_field("read_data", want.read_data, read_data);
				check_field("forward_valid", want.forward_valid, forward_valid);
				check_field("forward_byte", want.forward_byte, forward_byte);
				results_checked++;
				if (!$isunknown(status))
					status_hits[status]++;
			end
		end
	end

	// watchdog: too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, awaited_responses.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(MODE_RECEIVE);
		test_directed_cases();
		test_store_overflow();
		test_count_saturation();
		test_random_traffic(0, 0, 320);
		test_random_traffic(50, 0, 320);
		test_random_traffic(0, 50, 320);
		test_random_traffic(10, 10, 320);
		test_other_modes();
		test_random_traffic(10, 10, 100);
		drain();
		$display("Sent %0d items, checked %0d results over modes 0 to 3 and four idling mixes.",
			items_sent, results_checked);
		$display("Frames closed: %0d by A, %0d by CR LF, %0d by overflow; %0d bytes forwarded.",
			status_hits[ST_DONE_A], status_hits[ST_DONE_CRLF],
			status_hits[ST_OVERFLOW], status_hits[ST_FORWARD]);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
